// ===== rtl/cqf_slot_admission_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef CQF_SLOT_ADMISSION_UNIT_ASSERT_SVH
`define CQF_SLOT_ADMISSION_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CQF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CQF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cqf_pkg.sv =====
// types, constants and sizes shared by the slot admission unit
package cqf_pkg;

  localparam int NODES     = 8;
  localparam int PORTS     = 8;
  localparam int MAX_SLOTS = 256;
  localparam int DEPTH     = NODES * PORTS * MAX_SLOTS;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int HP_W      = 9;
  localparam int CAP_W     = 12;
  localparam int SW_W      = 3;
  localparam int HOST_W    = 3;
  localparam int OFF_W     = 8;
  localparam int PER_W     = 9;
  localparam int PKT_W     = 4;
  localparam int HITS_W    = 16;
  localparam int OCC_W     = 16;
  localparam int PORT_W    = 4;
  localparam int ACC_W     = HP_W + 1;

  localparam int MOD_STEPS = HP_W;
  localparam int MOD_K_W   = $clog2(MOD_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_HP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP = 2'd1;

  localparam logic [HP_W-1:0]  HP_RESET  = 9'd1;
  localparam logic [CAP_W-1:0] CAP_RESET = 12'd16;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADMIT = 1'b1;

  localparam logic [PORT_W-1:0] PORT_UP        = 4'd0;
  localparam logic [PORT_W-1:0] PORT_DOWN      = 4'd1;
  localparam logic [PORT_W-1:0] HOST_PORT_BASE = 4'd2;

  typedef struct packed {
    logic              op;
    logic [SW_W-1:0]   src;
    logic [SW_W-1:0]   dst;
    logic [HOST_W-1:0] host;
    logic [OFF_W-1:0]  offset;
    logic [PER_W-1:0]  period;
    logic [PKT_W-1:0]  packets;
  } cmd_t;

  typedef struct packed {
    logic [HP_W-1:0]  hp;
    logic [CAP_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic              admitted;
    logic [HITS_W-1:0] hits;
  } res_t;

endpackage

// ===== rtl/cqf_ram.sv =====
// single-port synchronous ram with registered read data
module cqf_ram #(
  parameter int Depth = 16384,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cqf_mod.sv =====
// iterative shift-subtract modulo unit, one quotient bit per cycle
module cqf_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cqf_pkg::HP_W-1:0]   value_i,
  input  logic [cqf_pkg::HP_W-1:0]   modulus_i,
  output logic                       done_o,
  output logic [cqf_pkg::HP_W-1:0]   rem_o
);

  localparam int WIDE_W = cqf_pkg::HP_W + cqf_pkg::MOD_STEPS;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cqf_pkg::MOD_K_W-1:0]   k_q, k_d;
  logic [cqf_pkg::HP_W-1:0]      rem_q, rem_d;
  logic [WIDE_W-1:0]             shifted;

  assign shifted = WIDE_W'(modulus_i) << k_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = cqf_pkg::MOD_K_W'(cqf_pkg::MOD_STEPS - 1);
      rem_d  = value_i;
    end else if (busy_q) begin
      if (WIDE_W'(rem_q) >= shifted) begin
        rem_d = rem_q - shifted[cqf_pkg::HP_W-1:0];
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/cqf_engine.sv =====
// sequencer that walks a flow through the occupancy ram and clears it
module cqf_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cqf_pkg::cmd_t   cmd_i,
  input  cqf_pkg::cfg_t   cfg_i,
  output logic            idle_o,
  output logic            done_valid_o,
  input  logic            done_ready_i,
  output cqf_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HOP,
    S_RD,
    S_WR,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  cqf_pkg::cmd_t                 cmd_q, cmd_d;
  logic                          undo_q, undo_d;
  logic                          up_q, up_d;
  logic                          clr_cmd_q, clr_cmd_d;
  logic [cqf_pkg::HITS_W-1:0]    hits_q, hits_d;
  logic [cqf_pkg::SW_W-1:0]      hop_q, hop_d;
  logic [cqf_pkg::SW_W-1:0]      span_q, span_d;
  logic [cqf_pkg::HP_W-1:0]      base_q, base_d;
  logic [cqf_pkg::HP_W-1:0]      base0_q, base0_d;
  logic [cqf_pkg::HP_W-1:0]      slot_q, slot_d;
  logic [cqf_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic [cqf_pkg::ADDR_W-1:0]    clr_addr_q, clr_addr_d;

  logic [cqf_pkg::HP_W-1:0]      period_eff;
  logic [cqf_pkg::SW_W-1:0]      node;
  logic [cqf_pkg::PORT_W-1:0]    port;
  logic                          last_hop;
  logic                          hop_ok;
  logic                          reps_ok;
  logic [cqf_pkg::ADDR_W-1:0]    walk_addr;
  logic [cqf_pkg::OCC_W-1:0]     rdata;
  logic [cqf_pkg::OCC_W:0]       add_sum;
  logic [cqf_pkg::OCC_W-1:0]     add_v;
  logic [cqf_pkg::OCC_W-1:0]     sub_v;
  logic [cqf_pkg::OCC_W-1:0]     new_v;
  logic [cqf_pkg::ACC_W-1:0]     acc_next;
  logic [cqf_pkg::ACC_W-1:0]     slot_sum;
  logic [cqf_pkg::HP_W-1:0]      slot_next;
  logic [cqf_pkg::ACC_W-1:0]     base_sum;
  logic [cqf_pkg::HP_W-1:0]      base_inc;
  logic                          hop_end;

  logic                          mod_start;
  logic [cqf_pkg::HP_W-1:0]      mod_value;
  logic                          mod_done;
  logic [cqf_pkg::HP_W-1:0]      mod_rem;

  logic                          ram_en;
  logic                          ram_we;
  logic [cqf_pkg::ADDR_W-1:0]    ram_addr;
  logic [cqf_pkg::OCC_W-1:0]     ram_wdata;

  assign period_eff = (cmd_q.period == '0) ? cqf_pkg::HP_W'(1) : cmd_q.period;
  assign node       = up_q ? (cmd_q.src + hop_q) : (cmd_q.src - hop_q);
  assign last_hop   = (hop_q == span_q);
  assign port       = last_hop ? (cqf_pkg::PORT_W'(cmd_q.host) + cqf_pkg::HOST_PORT_BASE)
                               : (up_q ? cqf_pkg::PORT_UP : cqf_pkg::PORT_DOWN);
  assign hop_ok     = (int'(node) < cqf_pkg::NODES) && (int'(port) < cqf_pkg::PORTS);
  assign reps_ok    = cqf_pkg::ACC_W'(period_eff) <= cqf_pkg::ACC_W'(cfg_i.hp);
  assign walk_addr  = cqf_pkg::ADDR_W'((int'(node) * cqf_pkg::PORTS + int'(port))
                                       * cqf_pkg::MAX_SLOTS + int'(slot_q));

  assign add_sum = (cqf_pkg::OCC_W + 1)'(rdata) + (cqf_pkg::OCC_W + 1)'(cmd_q.packets);
  assign add_v   = add_sum[cqf_pkg::OCC_W] ? '1 : add_sum[cqf_pkg::OCC_W-1:0];
  assign sub_v   = (rdata >= cqf_pkg::OCC_W'(cmd_q.packets))
                   ? (rdata - cqf_pkg::OCC_W'(cmd_q.packets)) : '0;
  assign new_v   = undo_q ? sub_v : add_v;

  assign acc_next  = acc_q + cqf_pkg::ACC_W'(period_eff);
  assign slot_sum  = cqf_pkg::ACC_W'(slot_q) + cqf_pkg::ACC_W'(period_eff);
  assign slot_next = (slot_sum >= cqf_pkg::ACC_W'(cfg_i.hp))
                     ? cqf_pkg::HP_W'(slot_sum - cqf_pkg::ACC_W'(cfg_i.hp))
                     : slot_sum[cqf_pkg::HP_W-1:0];
  assign base_sum  = cqf_pkg::ACC_W'(base_q) + cqf_pkg::ACC_W'(1);
  assign base_inc  = (base_sum == cqf_pkg::ACC_W'(cfg_i.hp)) ? '0
                                                             : base_sum[cqf_pkg::HP_W-1:0];

  assign mod_start = (state_q == S_IDLE) && start_i && (cmd_i.op == cqf_pkg::OP_ADMIT);
  assign mod_value = cqf_pkg::HP_W'(cmd_i.offset) + cqf_pkg::HP_W'(1);

  cqf_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .value_i   (mod_value),
    .modulus_i (cfg_i.hp),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign ram_en    = (state_q == S_CLEAR) || (state_q == S_RD) || (state_q == S_WR);
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
  assign ram_addr  = (state_q == S_CLEAR) ? clr_addr_q : walk_addr;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : new_v;

  cqf_ram #(
    .Depth (cqf_pkg::DEPTH),
    .Width (cqf_pkg::OCC_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    undo_d     = undo_q;
    up_d       = up_q;
    clr_cmd_d  = clr_cmd_q;
    hits_d     = hits_q;
    hop_d      = hop_q;
    span_d     = span_q;
    base_d     = base_q;
    base0_d    = base0_q;
    slot_d     = slot_q;
    acc_d      = acc_q;
    clr_addr_d = clr_addr_q;
    hop_end    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == cqf_pkg::ADDR_W'(cqf_pkg::DEPTH - 1)) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          hits_d = '0;
          undo_d = 1'b0;
          up_d   = cmd_i.src < cmd_i.dst;
          span_d = (cmd_i.src < cmd_i.dst) ? (cmd_i.dst - cmd_i.src)
                                           : (cmd_i.src - cmd_i.dst);
          if (cmd_i.op == cqf_pkg::OP_CLEAR) begin
            clr_addr_d = '0;
            clr_cmd_d  = 1'b1;
            state_d    = S_CLEAR;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          base_d  = mod_rem;
          base0_d = mod_rem;
          hop_d   = '0;
          state_d = S_HOP;
        end
      end
      S_HOP: begin
        if (hop_ok && reps_ok) begin
          slot_d  = base_q;
          acc_d   = cqf_pkg::ACC_W'(period_eff);
          state_d = S_RD;
        end else begin
          hop_end = 1'b1;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (!undo_q && (add_v > cqf_pkg::OCC_W'(cfg_i.cap)) && (hits_q != '1)) begin
          hits_d = hits_q + 1'b1;
        end
        if (acc_next <= cqf_pkg::ACC_W'(cfg_i.hp)) begin
          acc_d   = acc_next;
          slot_d  = slot_next;
          state_d = S_RD;
        end else begin
          hop_end = 1'b1;
        end
      end
      S_DONE: begin
        if (done_ready_i) begin
          clr_cmd_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // the hit count read here is final: a pass ends only after its last write
    if (hop_end) begin
      if (last_hop) begin
        if (!undo_q && (hits_d != '0)) begin
          undo_d  = 1'b1;
          hop_d   = '0;
          base_d  = base0_q;
          state_d = S_HOP;
        end else begin
          state_d = S_DONE;
        end
      end else begin
        hop_d   = hop_q + 1'b1;
        base_d  = base_inc;
        state_d = S_HOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cmd_q      <= '0;
      undo_q     <= 1'b0;
      up_q       <= 1'b0;
      clr_cmd_q  <= 1'b0;
      hits_q     <= '0;
      hop_q      <= '0;
      span_q     <= '0;
      base_q     <= '0;
      base0_q    <= '0;
      slot_q     <= '0;
      acc_q      <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      undo_q     <= undo_d;
      up_q       <= up_d;
      clr_cmd_q  <= clr_cmd_d;
      hits_q     <= hits_d;
      hop_q      <= hop_d;
      span_q     <= span_d;
      base_q     <= base_d;
      base0_q    <= base0_d;
      slot_q     <= slot_d;
      acc_q      <= acc_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign idle_o         = (state_q == S_IDLE);
  assign done_valid_o   = (state_q == S_DONE);
  assign res_o.admitted = (hits_q == '0);
  assign res_o.hits     = hits_q;

endmodule

// ===== rtl/cqf_slot_admission_unit.sv =====
// top level of the cyclic queuing slot admission unit
// Input words arrive on s_axis: tuser carries the opcode (clear or admit), tdata the
// flow description. One result word per input word leaves on m_axis: tuser is the
// admitted flag, tdata the saturating count of slot additions above capacity.
// Registers hyperperiod_slots and queue_capacity are written on the cfg port, which
// is always ready; write them only while no word is in flight.
// Items are handled one at a time. An admit word first runs through the modulo
// unit, then visits each hop in turn; every slot access is a read and a write of the
// single ram port. Accesses are hops times hyperperiod/period, and a refused flow
// walks its path a second time to undo. A clear word sweeps the ram one entry a
// cycle, then returns admitted with zero hits. After reset the same sweep runs with
// s_axis_tready low; registers come up as hyperperiod 1 and capacity 16. The result
// sits in an output register: a stalled receiver holds it there, the next word is
// still taken and worked on, and its result waits until the register frees.
module cqf_slot_admission_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // src_switch, dst_switch, dst_host, start_offset, period_in_slots, packets, pad
  input  logic [31:0]                    s_axis_tdata,
  // opcode
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // overflow_hits
  output logic [15:0]                    m_axis_tdata,
  // admitted
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cqf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [cqf_pkg::HP_W-1:0]   hp_q, hp_d;
  logic [cqf_pkg::CAP_W-1:0]  cap_q, cap_d;
  cqf_pkg::cfg_t              cfg;
  cqf_pkg::cmd_t              cmd;
  cqf_pkg::res_t              res;
  logic                       eng_idle;
  logic                       eng_start;
  logic                       done_valid;
  logic                       done_ready;
  logic                       out_valid_q, out_valid_d;
  cqf_pkg::res_t              out_res_q, out_res_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    hp_d  = hp_q;
    cap_d = cap_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cqf_pkg::CFG_HP:  hp_d  = cfg_data_i[cqf_pkg::HP_W-1:0];
        cqf_pkg::CFG_CAP: cap_d = cfg_data_i[cqf_pkg::CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero hyperperiod acts as one, larger than the store saturates
  always_comb begin
    if (hp_q == '0) begin
      cfg.hp = cqf_pkg::HP_W'(1);
    end else if (int'(hp_q) > cqf_pkg::MAX_SLOTS) begin
      cfg.hp = cqf_pkg::HP_W'(cqf_pkg::MAX_SLOTS);
    end else begin
      cfg.hp = hp_q;
    end
    cfg.cap = cap_q;
  end

  assign cmd.op      = s_axis_tuser[0];
  assign cmd.src     = s_axis_tdata[2:0];
  assign cmd.dst     = s_axis_tdata[5:3];
  assign cmd.host    = s_axis_tdata[8:6];
  assign cmd.offset  = s_axis_tdata[16:9];
  assign cmd.period  = s_axis_tdata[25:17];
  assign cmd.packets = s_axis_tdata[29:26];

  assign s_axis_tready = eng_idle;
  assign eng_start     = s_axis_tvalid && eng_idle;

  cqf_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (eng_start),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .idle_o       (eng_idle),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .res_o        (res)
  );

  assign done_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (done_valid && done_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= cqf_pkg::HP_RESET;
      cap_q       <= cqf_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      hp_q        <= hp_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_res_q.hits;
  assign m_axis_tuser[0] = out_res_q.admitted;

endmodule

// ===== rtl/cqf_chk.sv =====
// port-level checker for the slot admission unit and its bind
`include "cqf_slot_admission_unit_assert.svh"

module cqf_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [31:0]                    s_axis_tdata,
  input logic [0:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [15:0]                    m_axis_tdata,
  input logic [0:0]                     m_axis_tuser,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [cqf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [cqf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // a held result word keeps its value
  `CQF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // one word in work at a time
  `CQF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again right after a word was accepted")

  // admitted exactly when no overflow was counted
  `CQF_ASSERT_SAME(a_admit_vs_hits, m_axis_tvalid, m_axis_tuser[0] == (m_axis_tdata == 16'd0), "admitted flag disagrees with overflow count")

endmodule

bind cqf_slot_admission_unit cqf_chk u_cqf_chk (.*);

// ===== sim/cqf_slot_admission_unit_tb.sv =====
// testbench for the slot admission unit: random and directed flows checked against a slot ledger
`timescale 1ns / 1ps

import cqf_pkg::*;

class admission_scoreboard;
  bit [OCC_W-1:0] occupancy [DEPTH];
  bit [HP_W-1:0]  hyperperiod;
  bit [CAP_W-1:0] capacity;
  res_t           verdicts [$];
  int             errors;

  function new();
    wipe_store();
    hyperperiod = HP_RESET;
    capacity    = CAP_RESET;
    errors      = 0;
  endfunction

  function void wipe_store();
    foreach (occupancy[i]) occupancy[i] = '0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HP:  hyperperiod = data[HP_W-1:0];
      CFG_CAP: capacity = data[CAP_W-1:0];
      default: ;
    endcase
  endfunction

  // adds or removes the flow along its path, returns the overflow count when adding
  function int unsigned walk_path(cmd_t c, bit undo);
    int unsigned span, per, reps, len, node, port, slot, idx, level, hits;
    bit up;
    span = hyperperiod;
    if (span == 0) span = 1;
    if (span > MAX_SLOTS) span = MAX_SLOTS;
    per = c.period;
    if (per == 0) per = 1;
    reps = span / per;
    up = c.src < c.dst;
    len = up ? int'(c.dst) - int'(c.src) + 1 : int'(c.src) - int'(c.dst) + 1;
    hits = 0;
    for (int unsigned h = 0; h < len; h++) begin
      node = up ? int'(c.src) + h : int'(c.src) - h;
      port = (h + 1 == len) ? int'(c.host) + int'(HOST_PORT_BASE) :
             (up ? int'(PORT_UP) : int'(PORT_DOWN));
      if (node >= NODES || port >= PORTS) continue;
      for (int unsigned r = 0; r < reps; r++) begin
        slot  = (int'(c.offset) + r * per + h + 1) % span;
        idx   = (node * PORTS + port) * MAX_SLOTS + slot;
        level = occupancy[idx];
        if (undo) begin
          level = (level >= c.packets) ? level - c.packets : 0;
          occupancy[idx] = level[OCC_W-1:0];
        end else begin
          level = level + c.packets;
          if (level > 32'hFFFF) level = 32'hFFFF;
          occupancy[idx] = level[OCC_W-1:0];
          if (level > capacity && hits < 32'hFFFF) hits++;
        end
      end
    end
    return hits;
  endfunction

  function void note_request(cmd_t c);
    res_t e;
    int unsigned hits;
    if (c.op == OP_CLEAR) begin
      wipe_store();
      e.admitted = 1'b1;
      e.hits     = '0;
    end else begin
      hits = walk_path(c, 1'b0);
      if (hits != 0) void'(walk_path(c, 1'b1));
      e.admitted = (hits == 0);
      e.hits     = hits[HITS_W-1:0];
    end
    verdicts.push_back(e);
  endfunction

  task report_mismatch(string msg);
    if (errors < 100) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic admitted, logic [HITS_W-1:0] hits);
    res_t e;
    if (verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected word, admitted %0b hits %0d", admitted, hits));
      return;
    end
    e = verdicts.pop_front();
    if (admitted !== e.admitted)
      report_mismatch($sformatf("admitted %0b, expected %0b", admitted, e.admitted));
    if (hits !== e.hits)
      report_mismatch($sformatf("overflow hits %0d, expected %0d", hits, e.hits));
  endtask

  function int pending();
    return verdicts.size();
  endfunction
endclass

module cqf_slot_admission_unit_tb;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  admission_scoreboard ledger;
  int cycles;
  int stall_left;
  int hold_left;
  bit steady;
  bit hold_req;

  cqf_slot_admission_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cqf_slot_admission_unit_tb failed");
      $finish;
    end
  end

  // result side: ready with short and long stalls, one forced long hold
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  m_axis_tready <= 1'b1;
          [65:92]: begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
          end
          default: begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(20, 120);
          end
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        ledger.check_result(m_axis_tuser[0], m_axis_tdata);
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 99)) inside
      [0:49]:  return 0;
      [50:91]: return $urandom_range(1, 3);
      default: return $urandom_range(10, 60);
    endcase
  endfunction

  function automatic cmd_t flow_word(logic [SW_W-1:0] src, logic [SW_W-1:0] dst,
                                     logic [HOST_W-1:0] host, logic [OFF_W-1:0] offset,
                                     logic [PER_W-1:0] period, logic [PKT_W-1:0] packets);
    cmd_t c;
    c.op      = OP_ADMIT;
    c.src     = src;
    c.dst     = dst;
    c.host    = host;
    c.offset  = offset;
    c.period  = period;
    c.packets = packets;
    return c;
  endfunction

  function automatic cmd_t clear_word();
    cmd_t c;
    c = flow_word(SW_W'($urandom), SW_W'($urandom), HOST_W'($urandom),
                  OFF_W'($urandom), PER_W'($urandom), PKT_W'($urandom));
    c.op = OP_CLEAR;
    return c;
  endfunction

  function automatic cmd_t random_flow(int unsigned span);
    cmd_t c;
    int unsigned pick;
    if ($urandom_range(0, 99) < 3) return clear_word();
    c.op     = OP_ADMIT;
    c.src    = SW_W'($urandom_range(0, 7));
    c.dst    = SW_W'($urandom_range(0, 7));
    c.host   = ($urandom_range(0, 9) == 0) ? HOST_W'($urandom_range(6, 7))
                                           : HOST_W'($urandom_range(0, 5));
    c.offset = OFF_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 70)      c.period = PER_W'($urandom_range(1, span));
    else if (pick < 78) c.period = '0;
    else                c.period = PER_W'($urandom_range(0, 511));
    c.packets = ($urandom_range(0, 19) == 0) ? 4'd0 : PKT_W'($urandom_range(1, 15));
    return c;
  endfunction

  task automatic send_word(cmd_t c, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c.packets, c.period, c.offset, c.host, c.dst, c.src};
    s_axis_tuser  <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_request(c);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_registers(logic [CFG_DATA_W-1:0] hp_data, logic [CFG_DATA_W-1:0] cap_data);
    write_register(CFG_HP, hp_data);
    write_register(CFG_CAP, cap_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] hp_data, logic [CFG_DATA_W-1:0] cap_data,
                           int count, int unsigned span, bit pressure);
    int gap;
    load_registers(hp_data, cap_data);
    for (int i = 0; i < count; i++) begin
      gap = pick_gap();
      if (pressure && i == 10) hold_req = 1'b1;
      if (pressure && i >= 10 && i < 24) gap = 0;
      send_word(random_flow(span), gap);
    end
    settle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    ledger        = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one slot, capacity 16
    send_word(flow_word(0, 7, 0, 0, 1, 15), pick_gap());
    send_word(flow_word(0, 7, 0, 0, 1, 1), pick_gap());
    send_word(flow_word(0, 7, 0, 0, 1, 1), pick_gap());
    send_word(flow_word(7, 0, 5, 0, 0, 15), pick_gap());
    send_word(flow_word(3, 3, 7, 0, 1, 15), pick_gap());
    send_word(flow_word(2, 5, 6, 255, 1, 15), pick_gap());
    send_word(flow_word(1, 6, 3, 255, 511, 15), pick_gap());
    send_word(flow_word(6, 6, 0, 128, 2, 0), pick_gap());
    send_word(clear_word(), pick_gap());
    settle();

    // zero hyperperiod and zero capacity
    write_register(CFG_HP, '0);
    write_register(CFG_CAP, '0);
    write_register(CFG_UNUSED, '1);
    cfg_valid_i <= 1'b0;
    send_word(flow_word(4, 1, 2, 0, 0, 1), pick_gap());
    send_word(flow_word(5, 5, 7, 0, 1, 3), pick_gap());
    settle();

    // hyperperiod above the maximum, full capacity
    load_registers(12'd511, 12'd4095);
    send_word(flow_word(0, 7, 5, 0, 1, 15), pick_gap());
    send_word(flow_word(7, 0, 0, 255, 256, 15), pick_gap());
    send_word(flow_word(7, 0, 0, 255, 257, 15), pick_gap());
    send_word(flow_word(0, 7, 5, 17, 1, 15), pick_gap());
    settle();

    load_registers(12'd3, 12'd15);
    send_word(flow_word(2, 4, 1, 0, 1, 15), pick_gap());
    send_word(flow_word(2, 4, 1, 0, 1, 1), pick_gap());
    send_word(clear_word(), pick_gap());
    settle();

    run_phase(12'h610, 12'd24, 60, 16, 1'b0);
    run_phase(12'd256, 12'd4095, 40, 256, 1'b0);
    run_phase(12'd5, 12'd0, 20, 5, 1'b0);
    run_phase(12'd0, 12'd16, 20, 1, 1'b0);
    run_phase(12'd400, 12'd40, 40, 256, 1'b0);
    steady = 1'b1;
    run_phase(12'd1, 12'd1, 30, 1, 1'b0);
    steady = 1'b0;
    run_phase(12'd37, 12'd60, 80, 37, 1'b1);

    repeat (40) @(posedge clk_i);
    if (ledger.errors == 0)
      $display("cqf_slot_admission_unit_tb passed");
    else
      $display("cqf_slot_admission_unit_tb failed");
    $finish;
  end
endmodule
